### src/prp_pkg.sv
// ----------------------------------------------------------------------------
// Priority resource pool package
// Shared types and codes for the resource pool and its wait-queue memory.
// ----------------------------------------------------------------------------
package prp_pkg;

  localparam int unsigned IdW    = 8;
  localparam int unsigned NeedW  = 16;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CountW = 5;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [StatW-1:0] {
    STS_GRANTED   = 3'd0,
    STS_QUEUED    = 3'd1,
    STS_REJECTED  = 3'd2,
    STS_RELEASED  = 3'd3,
    STS_REL_GRANT = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_REL
  } state_e;

  // One waiting request as it sits in the queue memory
  typedef struct packed {
    logic [IdW-1:0]   who;
    logic [NeedW-1:0] need;
    logic [PrioW-1:0] prio;
  } waiter_t;

endpackage

### src/prp_wait_ram.sv
// ----------------------------------------------------------------------------
// Wait-queue memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module prp_wait_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  prp_pkg::waiter_t      wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output prp_pkg::waiter_t      rdata_o
);
  import prp_pkg::*;

  waiter_t mem_q [Depth];
  waiter_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/priority_resource_pool_unit.sv
// ----------------------------------------------------------------------------
// Priority resource pool unit
// Counting semaphore with a wait queue sorted by ascending priority number.
// ----------------------------------------------------------------------------
// Command flow: grant, reject, queue into an empty queue, release with none waiting:
//   done in ST_IDLE (busy stays low); release with waiters: through ST_REL (one
//   queue-memory read); sorted insert: through ST_SHIFT, one move per cycle, and
//   through ST_PLACE when the new request reaches the head.
// Reset: pool level and queue length clear to zero, queue contents are left.
// The receiver cannot stall: done_o marks each result for one cycle only.
module priority_resource_pool_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned UNIT_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [prp_pkg::NeedW-1:0]     cfg_wdata_i,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind_i,
  input  logic [prp_pkg::IdW-1:0]       requester_i,
  input  logic [prp_pkg::NeedW-1:0]     units_i,
  input  logic [prp_pkg::PrioW-1:0]     priority_req_i,
  // result side
  output logic                          done_o,
  output logic [prp_pkg::StatW-1:0]     status_o,
  output logic [prp_pkg::IdW-1:0]       granted_requester_o,
  output logic [prp_pkg::NeedW-1:0]     pool_level_o,
  output logic [prp_pkg::CountW-1:0]    waiting_count_o,
  output logic                          saturated_o
);
  import prp_pkg::*;

  // Widths: queue address, queue length, pool, and compare width covering both
  // the pool and a 16-bit request.
  localparam int unsigned AW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW = UNIT_BITS;
  localparam int unsigned CW = (PW > NeedW) ? PW : NeedW;
  localparam int unsigned SW = CW + 1;

  localparam logic [AW:0]   DEPTH_W  = QUEUE_DEPTH[AW:0];
  localparam logic [LW-1:0] DEPTH_L  = QUEUE_DEPTH[LW-1:0];
  localparam logic [PW-1:0] POOL_MAX = {PW{1'b1}};

  // Map a position in the queue (0 = head) onto a memory address. The sum is
  // below twice the depth, so one compare and subtract wraps it.
  function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] head,
                                              input logic [AW-1:0] slot);
    logic [AW:0] s;
    logic [AW:0] t;
    s = {1'b0, head} + {1'b0, slot};
    t = s - DEPTH_W;
    return (s >= DEPTH_W) ? t[AW-1:0] : s[AW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e         state_q, state_d;
  logic [PW-1:0]  pool_q, pool_d;
  logic [AW-1:0]  head_q, head_d;
  logic [LW-1:0]  len_q, len_d;
  logic [AW-1:0]  pos_q, pos_d;        // hole position during a sorted insert
  logic           sat_pend_q, sat_pend_d;
  waiter_t        new_q, new_d;        // allocate transaction being queued

  // result registers
  logic           done_q;
  status_e        status_q;
  logic [IdW-1:0] gid_q;
  logic [PW-1:0]  lvl_q;
  logic [LW-1:0]  cnt_q;
  logic           sat_q;

  // memory ports
  logic           mem_we;
  logic [AW-1:0]  wslot, rslot;
  waiter_t        mem_wdata, mem_rdata;

  // emit controls
  logic           emit;
  status_e        emit_status;
  logic [IdW-1:0] emit_gid;
  logic           emit_sat;

  // arithmetic on the current transaction
  logic [CW-1:0]  pool_x, units_x, need_x;
  logic [SW-1:0]  rel_sum;
  logic           rel_sat;
  logic [PW-1:0]  rel_pool;
  logic           accept;

  assign accept  = start && !busy;
  assign pool_x  = CW'(pool_q);
  assign units_x = CW'(units_i);
  assign need_x  = CW'(mem_rdata.need);
  assign rel_sum = SW'(pool_q) + SW'(units_i);
  assign rel_sat = rel_sum > SW'(POOL_MAX);
  assign rel_pool = rel_sat ? POOL_MAX : rel_sum[PW-1:0];

  // --------------------------------------------------------------------------
  // Wait-queue memory. Reads are only ever issued for entries written in an
  // earlier cycle, and the write in the shift walk is two slots above the
  // read, so no forwarding path is needed.
  // --------------------------------------------------------------------------
  prp_wait_ram #(
    .Depth (QUEUE_DEPTH),
    .AddrW (AW)
  ) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (phys_addr(head_q, wslot)),
    .wdata_i (mem_wdata),
    .raddr_i (phys_addr(head_q, rslot)),
    .rdata_o (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pool_q  <= '0;
      head_q  <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pool_q  <= pool_d;
      head_q  <= head_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      done_q  <= emit;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    new_q      <= new_d;
    sat_pend_q <= sat_pend_d;
    if (emit) begin
      status_q <= emit_status;
      gid_q    <= emit_gid;
      lvl_q    <= pool_d;
      cnt_q    <= len_d;
      sat_q    <= emit_sat;
    end
  end

  // --------------------------------------------------------------------------
  // Next state and datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    pool_d      = pool_q;
    head_d      = head_q;
    len_d       = len_q;
    pos_d       = pos_q;
    sat_pend_d  = sat_pend_q;
    new_d       = new_q;
    mem_we      = 1'b0;
    wslot       = pos_q;
    mem_wdata   = new_q;
    rslot       = '0;
    emit        = 1'b0;
    emit_status = STS_GRANTED;
    emit_gid    = '0;
    emit_sat    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_ALLOC) begin
            if (pool_x >= units_x) begin
              // grant at once, even ahead of waiters
              pool_d      = pool_q - PW'(units_x);
              emit        = 1'b1;
              emit_status = STS_GRANTED;
            end else if (len_q < DEPTH_L) begin
              new_d = '{who: requester_i, need: units_i, prio: priority_req_i};
              if (len_q == '0) begin
                // empty queue: write straight to the head
                mem_we      = 1'b1;
                wslot       = '0;
                mem_wdata   = '{who: requester_i, need: units_i, prio: priority_req_i};
                len_d       = len_q + 1'b1;
                emit        = 1'b1;
                emit_status = STS_QUEUED;
              end else begin
                // start the walk from the tail
                pos_d   = len_q[AW-1:0];
                rslot   = AW'(len_q - 1'b1);
                state_d = ST_SHIFT;
              end
            end else begin
              emit        = 1'b1;
              emit_status = STS_REJECTED;
            end
          end else begin
            pool_d     = rel_pool;
            sat_pend_d = rel_sat;
            if (len_q == '0) begin
              emit        = 1'b1;
              emit_status = STS_RELEASED;
              emit_sat    = rel_sat;
            end else begin
              rslot   = '0;
              state_d = ST_REL;
            end
          end
        end
      end

      ST_SHIFT: begin
        // mem_rdata holds the entry just below the hole
        mem_we = 1'b1;
        wslot  = pos_q;
        rslot  = (pos_q >= AW'(2)) ? pos_q - AW'(2) : '0;
        if (mem_rdata.prio > new_q.prio) begin
          // move the entry up one slot, advance the hole down
          mem_wdata = mem_rdata;
          pos_d     = pos_q - 1'b1;
          if (pos_q == AW'(1)) begin
            state_d = ST_PLACE;
          end
        end else begin
          mem_wdata   = new_q;
          len_d       = len_q + 1'b1;
          emit        = 1'b1;
          emit_status = STS_QUEUED;
          state_d     = ST_IDLE;
        end
      end

      ST_PLACE: begin
        // new request lands at the head
        mem_we      = 1'b1;
        wslot       = '0;
        mem_wdata   = new_q;
        len_d       = len_q + 1'b1;
        emit        = 1'b1;
        emit_status = STS_QUEUED;
        state_d     = ST_IDLE;
      end

      ST_REL: begin
        // mem_rdata holds the head waiter; try it against the refilled pool
        emit     = 1'b1;
        emit_sat = sat_pend_q;
        state_d  = ST_IDLE;
        if (need_x <= pool_x) begin
          pool_d      = pool_q - PW'(need_x);
          head_d      = phys_addr(head_q, AW'(1));
          len_d       = len_q - 1'b1;
          emit_status = STS_REL_GRANT;
          emit_gid    = mem_rdata.who;
        end else begin
          emit_status = STS_RELEASED;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a register write reloads the pool; the queue is untouched
    if (cfg_we_i) begin
      pool_d = PW'(cfg_wdata_i);
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign busy                = (state_q != ST_IDLE);
  assign done_o              = done_q;
  assign status_o            = status_q;
  assign granted_requester_o = gid_q;
  assign pool_level_o        = NeedW'(lvl_q);
  assign waiting_count_o     = CountW'(cnt_q);
  assign saturated_o         = sat_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= DEPTH_L)
    else $error("queue length beyond depth");

  a_shift_hole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (pos_q != '0) && (LW'(pos_q) <= len_q))
    else $error("insert hole outside the occupied queue");

  a_gid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STS_REL_GRANT)) |-> (granted_requester_o == '0))
    else $error("granted id set without a waiter grant");

  a_busy_no_sat_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STS_GRANTED || status_o == STS_QUEUED ||
                status_o == STS_REJECTED)) |-> !saturated_o)
    else $error("saturation flagged on an allocate");

endmodule
